FILE: design/assert_macros.svh
// assertion macros used by the overlap pair finder datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication checked outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: design/lopf_pkg.sv
// shared types and constants for the lifespan overlap pair finder
`timescale 1ns / 1ps
`default_nettype none

package lopf_pkg;

  localparam int ACTIVE_DEPTH_DEF = 32;
  localparam int RESULT_LIMIT     = 32;
  localparam int CNT_W            = $clog2(RESULT_LIMIT + 1);
  localparam int ID_W             = 16;
  localparam int EPOCH_W          = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic start;
    logic step;
    logic finish;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic last_slot;
    logic step_ok;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: design/lifespan_overlap_pair_finder.sv
// Sweep-line overlap pair finder.
// Input channel: one beat per span (in_span_id, in_start_epoch, in_end_epoch),
// spans sorted by start epoch, taken when in_valid is high and in_stall low.
// Output channel: one beat per overlap pair with an active span, slot order,
// or a single beat with out_pair_valid low when nothing is active; out_last
// marks the final beat of a span and out_table_full is set there when the
// span found no free slot. At most 32 pairs are given per span.
// Sequence: the beat is taken, the retire-and-pair scan then steps through
// the entry memory slot by slot, and the final beat is loaded together with
// the insert. The next span can be taken in the cycle after the final beat
// is loaded.
// Reset: the table empties at once (valid bits clear) and the current epoch
// returns to one; no clearing pass is needed.
// Output stall: a finished beat waits in the output register; the scan halts
// on the next pair that needs that register until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none

module lifespan_overlap_pair_finder #(
  parameter int ACTIVE_DEPTH = lopf_pkg::ACTIVE_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [lopf_pkg::ID_W-1:0]    in_span_id,
  input  wire logic [lopf_pkg::EPOCH_W-1:0] in_start_epoch,
  input  wire logic [lopf_pkg::EPOCH_W-1:0] in_end_epoch,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [lopf_pkg::ID_W-1:0]         out_new_id,
  output logic [lopf_pkg::ID_W-1:0]         out_other_id,
  output logic                              out_pair_valid,
  output logic                              out_table_full,
  output logic                              out_last
);

  lopf_pkg::cmd_t cmd;
  lopf_pkg::sts_t sts;

  // sequencer
  lopf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table and result datapath
  lopf_dp #(
    .ACTIVE_DEPTH (ACTIVE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_span_id     (in_span_id),
    .in_start_epoch (in_start_epoch),
    .in_end_epoch   (in_end_epoch),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_new_id     (out_new_id),
    .out_other_id   (out_other_id),
    .out_pair_valid (out_pair_valid),
    .out_table_full (out_table_full),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

FILE: design/lopf_ctrl.sv
// controller state machine: accept, slot scan and final beat
`timescale 1ns / 1ps
`default_nettype none

module lopf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire lopf_pkg::sts_t sts,
  output lopf_pkg::cmd_t     cmd
);

  lopf_pkg::state_t state_r;
  lopf_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lopf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state_r)
      lopf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = lopf_pkg::ST_SCAN;
        end
      end
      lopf_pkg::ST_SCAN: begin
        if (sts.step_ok) begin
          cmd.step = 1'b1;
          if (sts.last_slot) begin
            state_nxt = lopf_pkg::ST_DONE;
          end
        end
      end
      lopf_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = lopf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lopf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/lopf_dp.sv
// datapath: active table, epoch, slot scan, pending pair and output register
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module lopf_dp #(
  parameter int ACTIVE_DEPTH = lopf_pkg::ACTIVE_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire lopf_pkg::cmd_t               cmd,
  output lopf_pkg::sts_t                    sts,
  input  wire logic [lopf_pkg::ID_W-1:0]    in_span_id,
  input  wire logic [lopf_pkg::EPOCH_W-1:0] in_start_epoch,
  input  wire logic [lopf_pkg::EPOCH_W-1:0] in_end_epoch,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [lopf_pkg::ID_W-1:0]         out_new_id,
  output logic [lopf_pkg::ID_W-1:0]         out_other_id,
  output logic                              out_pair_valid,
  output logic                              out_table_full,
  output logic                              out_last
);

  localparam int IDX_W = $clog2(ACTIVE_DEPTH);
  localparam int ENT_W = lopf_pkg::ID_W + lopf_pkg::EPOCH_W;
  localparam int CW    = lopf_pkg::CNT_W;

  // entry memory: span id above end epoch
  logic [ENT_W-1:0] mem [ACTIVE_DEPTH];
  logic [ENT_W-1:0] rd_data_r;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;

  logic [ACTIVE_DEPTH-1:0]     valid_r, valid_nxt;
  logic [lopf_pkg::EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic                        adv_r, adv_nxt;
  logic [lopf_pkg::ID_W-1:0]   id_r, id_nxt;
  logic [lopf_pkg::EPOCH_W-1:0] end_r, end_nxt;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic                        pend_v_r, pend_v_nxt;
  logic [lopf_pkg::ID_W-1:0]   pend_id_r, pend_id_nxt;
  logic                        free_found_r, free_found_nxt;
  logic [IDX_W-1:0]            free_slot_r, free_slot_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [lopf_pkg::ID_W-1:0]   out_new_id_r, out_new_id_nxt;
  logic [lopf_pkg::ID_W-1:0]   out_other_id_r, out_other_id_nxt;
  logic                        out_pair_valid_r, out_pair_valid_nxt;
  logic                        out_table_full_r, out_table_full_nxt;
  logic                        out_last_r, out_last_nxt;

  logic [lopf_pkg::ID_W-1:0]    rd_id;
  logic [lopf_pkg::EPOCH_W-1:0] rd_end;
  logic                         retain;
  logic                         take;
  logic                         out_free;
  logic                         last_slot;

  assign rd_id     = rd_data_r[ENT_W-1:lopf_pkg::EPOCH_W];
  assign rd_end    = rd_data_r[lopf_pkg::EPOCH_W-1:0];
  assign out_free  = !out_valid_r || !out_stall;
  assign last_slot = (idx_r == IDX_W'(ACTIVE_DEPTH - 1));

  // slot survives the retire check of the new epoch
  assign retain = valid_r[idx_r] && !(adv_r && (rd_end == epoch_r));
  assign take   = retain && (count_r < CW'(lopf_pkg::RESULT_LIMIT));

  // status to the controller
  always_comb begin
    sts.last_slot = last_slot;
    sts.step_ok   = !(take && pend_v_r) || out_free;
    sts.out_free  = out_free;
  end

  // memory read of the next slot and insert of the new span
  assign rd_en   = cmd.start || (cmd.step && !last_slot);
  assign rd_addr = cmd.start ? '0 : idx_r + IDX_W'(1);
  assign mem_we  = cmd.finish && free_found_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[free_slot_r] <= {id_r, end_r};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // scan, pairing and output next values
  always_comb begin
    valid_nxt          = valid_r;
    epoch_nxt          = epoch_r;
    adv_nxt            = adv_r;
    id_nxt             = id_r;
    end_nxt            = end_r;
    idx_nxt            = idx_r;
    count_nxt          = count_r;
    pend_v_nxt         = pend_v_r;
    pend_id_nxt        = pend_id_r;
    free_found_nxt     = free_found_r;
    free_slot_nxt      = free_slot_r;
    out_valid_nxt      = out_valid_r && out_stall;
    out_new_id_nxt     = out_new_id_r;
    out_other_id_nxt   = out_other_id_r;
    out_pair_valid_nxt = out_pair_valid_r;
    out_table_full_nxt = out_table_full_r;
    out_last_nxt       = out_last_r;

    if (cmd.start) begin
      adv_nxt        = (in_start_epoch != epoch_r);
      epoch_nxt      = epoch_r + lopf_pkg::EPOCH_W'(adv_nxt);
      id_nxt         = in_span_id;
      end_nxt        = in_end_epoch;
      idx_nxt        = '0;
      count_nxt      = '0;
      pend_v_nxt     = 1'b0;
      free_found_nxt = 1'b0;
    end

    if (cmd.step) begin
      if (!retain) begin
        valid_nxt[idx_r] = 1'b0;
        if (!free_found_r) begin
          free_found_nxt = 1'b1;
          free_slot_nxt  = idx_r;
        end
      end
      if (take) begin
        // the pair held back is now known not to be the last one
        if (pend_v_r) begin
          out_valid_nxt      = 1'b1;
          out_new_id_nxt     = id_r;
          out_other_id_nxt   = pend_id_r;
          out_pair_valid_nxt = 1'b1;
          out_table_full_nxt = 1'b0;
          out_last_nxt       = 1'b0;
        end
        pend_v_nxt  = 1'b1;
        pend_id_nxt = rd_id;
        count_nxt   = count_r + CW'(1);
      end
      if (!last_slot) begin
        idx_nxt = idx_r + IDX_W'(1);
      end
    end

    if (cmd.finish) begin
      out_valid_nxt      = 1'b1;
      out_new_id_nxt     = id_r;
      out_other_id_nxt   = pend_v_r ? pend_id_r : '0;
      out_pair_valid_nxt = pend_v_r;
      out_table_full_nxt = !free_found_r;
      out_last_nxt       = 1'b1;
      pend_v_nxt         = 1'b0;
      if (free_found_r) begin
        valid_nxt[free_slot_r] = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      epoch_r      <= lopf_pkg::EPOCH_W'(1);
      adv_r        <= 1'b0;
      idx_r        <= '0;
      count_r      <= '0;
      pend_v_r     <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      valid_r      <= valid_nxt;
      epoch_r      <= epoch_nxt;
      adv_r        <= adv_nxt;
      idx_r        <= idx_nxt;
      count_r      <= count_nxt;
      pend_v_r     <= pend_v_nxt;
      free_found_r <= free_found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    id_r             <= id_nxt;
    end_r            <= end_nxt;
    pend_id_r        <= pend_id_nxt;
    free_slot_r      <= free_slot_nxt;
    out_new_id_r     <= out_new_id_nxt;
    out_other_id_r   <= out_other_id_nxt;
    out_pair_valid_r <= out_pair_valid_nxt;
    out_table_full_r <= out_table_full_nxt;
    out_last_r       <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_new_id     = out_new_id_r;
  assign out_other_id   = out_other_id_r;
  assign out_pair_valid = out_pair_valid_r;
  assign out_table_full = out_table_full_r;
  assign out_last       = out_last_r;

  // checks
  `ASSERT_IMPL(a_count_limit, 1'b1, count_r <= CW'(lopf_pkg::RESULT_LIMIT), "pair count over limit")
  `ASSERT_IMPL(a_pend_counted, pend_v_r, count_r != '0, "held pair without count")
  `ASSERT_CLK(a_insert_marks, (cmd.finish && free_found_r) |=> valid_r[$past(free_slot_r)], "insert did not set valid")
  `ASSERT_CLK(a_full_no_free, (cmd.finish && !free_found_r) |=> (valid_r == '1), "table full flagged with a free slot")

endmodule

`default_nettype wire

FILE: tb/tb_lifespan_overlap_pair_finder.sv
// self-checking testbench for the lifespan overlap pair finder
`timescale 1ns / 1ps

module tb_lifespan_overlap_pair_finder;
  import lopf_pkg::*;

  localparam int DEPTH         = ACTIVE_DEPTH_DEF;
  localparam int RANDOM_SPANS  = 60;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = DEPTH + 8;
  localparam int REPORT_CAP    = 40;
  localparam int N_ROWS        = 11;

  // one output beat as the block presents it
  typedef struct packed {
    logic [ID_W-1:0] new_id;
    logic [ID_W-1:0] other_id;
    logic            pair_valid;
    logic            table_full;
    logic            last;
  } pair_beat_t;

  // one row of the directed stimulus; typed rows carry their single beat
  typedef struct packed {
    logic [ID_W-1:0]    span_id;
    logic [EPOCH_W-1:0] start_ep;
    logic [EPOCH_W-1:0] end_ep;
    logic [5:0]         repeat_n;
    logic               typed;
    logic [ID_W-1:0]    exp_other;
    logic               exp_pair;
    logic               exp_full;
  } span_row_t;

  localparam span_row_t DIRECTED_ROWS [N_ROWS] = '{
    // empty table straight after reset
    '{16'h0000, 32'd1,          32'd2,          6'd1,  1'b1, 16'h0000, 1'b0, 1'b0},
    // epoch steps, the only entry retires, table empty again
    '{16'hFFFF, 32'hFFFF_FFFF,  32'd3,          6'd1,  1'b1, 16'h0000, 1'b0, 1'b0},
    // same epoch, end at the top of the range
    '{16'h8001, 32'd2,          32'hFFFF_FFFF,  6'd1,  1'b0, 16'h0000, 1'b0, 1'b0},
    // start and end at zero, out of order
    '{16'h7FFE, 32'd0,          32'd0,          6'd1,  1'b0, 16'h0000, 1'b0, 1'b0},
    // fill every remaining slot in one epoch
    '{16'h0100, 32'd3,          32'd5,          6'd30, 1'b0, 16'h0000, 1'b0, 1'b0},
    // table full, span dropped
    '{16'h0200, 32'd3,          32'd5,          6'd1,  1'b0, 16'h0000, 1'b0, 1'b0},
    // epoch jump of more than one while still full
    '{16'h0300, 32'd9,          32'd6,          6'd1,  1'b0, 16'h0000, 1'b0, 1'b0},
    // bulk retire of the filler spans
    '{16'h0301, 32'd5,          32'd6,          6'd1,  1'b0, 16'h0000, 1'b0, 1'b0},
    // unsorted start epoch
    '{16'h0302, 32'd1,          32'd7,          6'd1,  1'b0, 16'h0000, 1'b0, 1'b0},
    // alternating bit patterns
    '{16'h5555, 32'hAAAA_AAAA,  32'd8,          6'd1,  1'b0, 16'h0000, 1'b0, 1'b0},
    '{16'hAAAA, 32'h5555_5555,  32'd9,          6'd1,  1'b0, 16'h0000, 1'b0, 1'b0}
  };

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [ID_W-1:0]     in_span_id;
  logic [EPOCH_W-1:0]  in_start_epoch;
  logic [EPOCH_W-1:0]  in_end_epoch;
  logic                out_valid;
  logic                out_stall;
  logic [ID_W-1:0]     out_new_id;
  logic [ID_W-1:0]     out_other_id;
  logic                out_pair_valid;
  logic                out_table_full;
  logic                out_last;

  // predictor state: active span table and sweep epoch
  logic                live_slot [DEPTH];
  logic [ID_W-1:0]     slot_span_id [DEPTH];
  logic [EPOCH_W-1:0]  slot_end_ep [DEPTH];
  logic [EPOCH_W-1:0]  epoch_now;

  pair_beat_t          pending_pairs [$];
  bit                  calm;
  int                  errors;
  int                  cycles;
  int                  spans_sent;
  int                  beats_seen;
  int                  pairs_seen;
  int                  full_seen;

  lifespan_overlap_pair_finder u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_span_id     (in_span_id),
    .in_start_epoch (in_start_epoch),
    .in_end_epoch   (in_end_epoch),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_new_id     (out_new_id),
    .out_other_id   (out_other_id),
    .out_pair_valid (out_pair_valid),
    .out_table_full (out_table_full),
    .out_last       (out_last)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // sweep one span through the table and list the beats it should give
  task automatic predict_overlaps(input logic [ID_W-1:0] id, input logic [EPOCH_W-1:0] st,
                                  input logic [EPOCH_W-1:0] en, output pair_beat_t beats[$]);
    int         free_slot;
    int         n;
    logic       full;
    pair_beat_t b;
    free_slot = -1;
    n = 0;
    beats = {};
    // any start other than the current epoch advances it by exactly one
    if (st != epoch_now) begin
      epoch_now = epoch_now + 1;
      for (int i = 0; i < DEPTH; i++)
        if (live_slot[i] && slot_end_ep[i] == epoch_now) live_slot[i] = 1'b0;
    end
    // pairs in slot order, capped at the result limit
    for (int i = 0; i < DEPTH; i++) begin
      if (live_slot[i]) begin
        if (n < RESULT_LIMIT) begin
          b = '{id, slot_span_id[i], 1'b1, 1'b0, 1'b0};
          beats.insert(beats.size(), b);
          n++;
        end
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    full = (free_slot < 0);
    if (!full) begin
      live_slot[free_slot]    = 1'b1;
      slot_span_id[free_slot] = id;
      slot_end_ep[free_slot]  = en;
    end
    // closing beat carries last and the full flag
    if (n == 0) begin
      b = '{id, {ID_W{1'b0}}, 1'b0, full, 1'b1};
      beats.insert(beats.size(), b);
    end else begin
      b = beats.pop_back();
      b.table_full = full;
      b.last = 1'b1;
      beats.insert(beats.size(), b);
    end
  endtask

  // present one span, wait for its beat to be taken, then queue its pairs
  task automatic send_span(input logic [ID_W-1:0] id, input logic [EPOCH_W-1:0] st,
                           input logic [EPOCH_W-1:0] en, input bit typed,
                           input pair_beat_t typed_beat);
    pair_beat_t beats[$];
    int         gap;
    if (!calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_span_id     <= id;
    in_start_epoch <= st;
    in_end_epoch   <= en;
    do @(posedge clk); while (in_stall);
    predict_overlaps(id, st, en, beats);
    if (typed) pending_pairs.insert(pending_pairs.size(), typed_beat);
    else foreach (beats[i]) pending_pairs.insert(pending_pairs.size(), beats[i]);
    spans_sent++;
  endtask

  // result side: random stall, check each taken beat against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      beats_seen++;
      if (out_pair_valid) pairs_seen++;
      if (out_table_full) full_seen++;
      if (pending_pairs.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t unexpected beat: new=%h other=%h pair=%b full=%b last=%b", $time,
                   out_new_id, out_other_id, out_pair_valid, out_table_full, out_last);
      end else begin
        if (pending_pairs[0] !== {out_new_id, out_other_id, out_pair_valid,
                                  out_table_full, out_last}) begin
          errors++;
          if (errors <= REPORT_CAP)
            $display("%0t mismatch: expected new=%h other=%h pair=%b full=%b last=%b,",
                     $time, pending_pairs[0].new_id, pending_pairs[0].other_id,
                     pending_pairs[0].pair_valid, pending_pairs[0].table_full,
                     pending_pairs[0].last,
                     " got new=%h other=%h pair=%b full=%b last=%b", out_new_id,
                     out_other_id, out_pair_valid, out_table_full, out_last);
        end
        void'(pending_pairs.pop_front());
      end
    end
    out_stall <= rst_n && !calm && ($urandom_range(0, 99) < 10);
  end

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t timeout with %0d beats outstanding", $time, pending_pairs.size());
      $display("tb_lifespan_overlap_pair_finder: FAIL");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int                 sel;
    int                 directed_spans;
    logic [EPOCH_W-1:0] st;
    logic [EPOCH_W-1:0] en;
    logic [EPOCH_W-1:0] next_ep;
    pair_beat_t         typed_beat;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_span_id     = '0;
    in_start_epoch = '0;
    in_end_epoch   = '0;
    out_stall      = 1'b0;
    calm           = 1'b0;
    errors         = 0;
    cycles         = 0;
    spans_sent     = 0;
    beats_seen     = 0;
    pairs_seen     = 0;
    full_seen      = 0;
    epoch_now      = 32'd1;
    for (int i = 0; i < DEPTH; i++) begin
      live_slot[i]    = 1'b0;
      slot_span_id[i] = '0;
      slot_end_ep[i]  = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows, repeated rows count the id upwards
    foreach (DIRECTED_ROWS[r]) begin
      for (int k = 0; k < DIRECTED_ROWS[r].repeat_n; k++) begin
        typed_beat = '{DIRECTED_ROWS[r].span_id + ID_W'(k), DIRECTED_ROWS[r].exp_other,
                       DIRECTED_ROWS[r].exp_pair, DIRECTED_ROWS[r].exp_full, 1'b1};
        send_span(DIRECTED_ROWS[r].span_id + ID_W'(k), DIRECTED_ROWS[r].start_ep,
                  DIRECTED_ROWS[r].end_ep, DIRECTED_ROWS[r].typed, typed_beat);
      end
    end
    directed_spans = spans_sent;

    // random sweep: mostly sorted spans with short lives, a same-epoch burst
    // to refill the table, and the odd jump, unsorted start or far end
    for (int k = 0; k < RANDOM_SPANS; k++) begin
      calm = (k >= 10 && k < 30);
      sel  = $urandom_range(0, 99);
      if ((k >= 32 && k < 57) || sel < 55) st = epoch_now;
      else if (sel < 85)                    st = epoch_now + 1;
      else                                  st = $urandom;
      next_ep = (st != epoch_now) ? epoch_now + 1 : epoch_now;
      en = ($urandom_range(0, 99) < 92) ? next_ep + $urandom_range(1, 8) : $urandom;
      send_span(ID_W'($urandom_range(0, 65535)), st, en, 1'b0, '0);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // drain, then watch for stray beats
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("spans sent: %0d (%0d directed), beats checked: %0d", spans_sent,
             directed_spans, beats_seen);
    $display("overlap pairs: %0d, table-full beats: %0d, errors: %0d", pairs_seen,
             full_seen, errors);
    if (errors == 0 && pending_pairs.size() == 0) begin
      $display("tb_lifespan_overlap_pair_finder: PASS");
    end else begin
      $display("tb_lifespan_overlap_pair_finder: FAIL");
    end
    $finish;
  end

endmodule
